FILE: src/lottery_arbiter_top_macros.svh
// Assertion helpers for the lottery arbiter.
// SYNTH drops every check to nothing.
`ifndef LOTTERY_ARBITER_TOP_MACROS_SVH
`define LOTTERY_ARBITER_TOP_MACROS_SVH

`ifndef SYNTH
`define LA_ASSERT_IMPL(label, clk, rst_n, ant, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("lottery arbiter check failed");
`define LA_ASSERT_NEXT(label, clk, rst_n, ant, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("lottery arbiter check failed");
`else
`define LA_ASSERT_IMPL(label, clk, rst_n, ant, cons)
`define LA_ASSERT_NEXT(label, clk, rst_n, ant, cons)
`endif

`endif

FILE: src/lotarb_pkg.sv
`default_nettype none

package lotarb_pkg;

  localparam int MAX_SLOTS  = 8;
  localparam int IDX_W      = 3;
  localparam int TICKET_W   = 5;
  localparam int TOTAL_W    = 8;
  localparam int LIVE_W     = 4;
  localparam int FRAC_W     = 16;
  localparam int TARGET_W   = TOTAL_W + FRAC_W;

  localparam logic CMD_DRAW       = 1'b0;
  localparam logic CMD_RETIRE     = 1'b1;
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  typedef struct packed {
    logic              command;
    logic [FRAC_W-1:0] random_fraction;
  } lotarb_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]   winner;
    logic               drew;
    logic               status;
    logic [LIVE_W-1:0]  live_count;
    logic [TOTAL_W-1:0] ticket_total;
  } lotarb_out_t;

  // Draw token walking the cell chain
  typedef struct packed {
    logic                active;
    logic                found;
    logic [IDX_W-1:0]    idx;
    logic [TOTAL_W-1:0]  prefix;
    logic [TARGET_W-1:0] target;
  } lotarb_link_t;

endpackage

`default_nettype wire

FILE: src/lottery_arbiter_top.sv
// Lottery arbiter over SLOTS slots, each holding TICKETS_EACH tickets. A draw item
// multiplies the 16-bit random fraction by the live ticket total, then sends a token
// down a chain of slot cells, one cell per clock, each live cell adding its tickets to the
// running prefix and claiming the win if the target falls strictly inside its range. One
// item is in work at a time; a finished result sits in the output register while the next
// item is taken.
`default_nettype none

`include "lottery_arbiter_top_macros.svh"

module lottery_arbiter_top #(
  parameter int SLOTS        = 8,
  parameter int TICKETS_EACH = 5
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire lotarb_pkg::lotarb_in_t in_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output lotarb_pkg::lotarb_out_t     out_data
);

  typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_SCAN, ST_RET, ST_FIN} state_t;

  state_t                            state_r;
  logic [lotarb_pkg::FRAC_W-1:0]     rnd_r;
  logic [lotarb_pkg::TOTAL_W-1:0]    total_r;
  logic [lotarb_pkg::LIVE_W-1:0]     live_r;
  logic [lotarb_pkg::IDX_W-1:0]      winner_r;
  logic                              winner_valid_r;
  lotarb_pkg::lotarb_link_t          head_r;
  lotarb_pkg::lotarb_out_t           res_r;
  lotarb_pkg::lotarb_out_t           out_data_r;
  logic                              out_valid_r;

  lotarb_pkg::lotarb_link_t          links [SLOTS+1];
  logic [SLOTS:0]                    actives;
  logic [lotarb_pkg::MAX_SLOTS-1:0]  live_all;
  logic                              ret_fire;
  logic [lotarb_pkg::TICKET_W-1:0]   tickets_each;
  lotarb_pkg::lotarb_link_t          tail;

  assign tickets_each = lotarb_pkg::TICKET_W'(TICKETS_EACH);
  assign links[0]     = head_r;
  assign tail         = links[SLOTS];

  genvar g;
  generate
    for (g = 0; g < lotarb_pkg::MAX_SLOTS; g++) begin : g_slot
      if (g < SLOTS) begin : g_cell
        lotarb_cell u_cell (
          .clk        (clk),
          .rst_n      (rst_n),
          .tickets    (tickets_each),
          .slot_idx   (lotarb_pkg::IDX_W'(g)),
          .link_in    (links[g]),
          .retire     (ret_fire),
          .retire_idx (winner_r),
          .live       (live_all[g]),
          .link_out   (links[g+1])
        );
      end else begin : g_empty
        assign live_all[g] = 1'b0;
      end
    end
    for (g = 0; g <= SLOTS; g++) begin : g_act
      assign actives[g] = links[g].active;
    end
  endgenerate

  assign ret_fire = (state_r == ST_RET) && winner_valid_r && live_all[winner_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      total_r        <= lotarb_pkg::TOTAL_W'(SLOTS * TICKETS_EACH);
      live_r         <= lotarb_pkg::LIVE_W'(SLOTS);
      winner_r       <= '0;
      winner_valid_r <= 1'b0;
      head_r         <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      // drain the output register; ST_FIN refills it itself
      if (out_valid_r && out_ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            rnd_r   <= in_data.random_fraction;
            state_r <= (in_data.command == lotarb_pkg::CMD_RETIRE) ? ST_RET : ST_MUL;
          end
        end
        ST_MUL: begin
          if (live_r == '0 || total_r == '0) begin
            res_r   <= '{winner_r, 1'b0, lotarb_pkg::STATUS_IGNORED, live_r, total_r};
            state_r <= ST_FIN;
          end else begin
            head_r.active <= 1'b1;
            head_r.found  <= 1'b0;
            head_r.idx    <= '0;
            head_r.prefix <= '0;
            head_r.target <= lotarb_pkg::TARGET_W'(rnd_r) * lotarb_pkg::TARGET_W'(total_r);
            state_r       <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          head_r.active <= 1'b0;
          // wait for the token to leave the last cell
          if (tail.active) begin
            if (tail.found) begin
              winner_r       <= tail.idx;
              winner_valid_r <= 1'b1;
              res_r <= '{tail.idx, 1'b1, lotarb_pkg::STATUS_DONE, live_r, total_r};
            end else begin
              res_r <= '{winner_r, 1'b0, lotarb_pkg::STATUS_DONE, live_r, total_r};
            end
            state_r <= ST_FIN;
          end
        end
        ST_RET: begin
          if (ret_fire) begin
            winner_valid_r <= 1'b0;
            total_r <= (total_r >= lotarb_pkg::TOTAL_W'(tickets_each)) ?
                       total_r - lotarb_pkg::TOTAL_W'(tickets_each) : '0;
            live_r  <= (live_r != '0) ? live_r - 1'b1 : '0;
            res_r   <= '{winner_r, 1'b0, lotarb_pkg::STATUS_DONE,
                         (live_r != '0) ? live_r - 1'b1 : live_r,
                         (total_r >= lotarb_pkg::TOTAL_W'(tickets_each)) ?
                         total_r - lotarb_pkg::TOTAL_W'(tickets_each) : '0};
          end else begin
            res_r <= '{winner_r, 1'b0, lotarb_pkg::STATUS_IGNORED, live_r, total_r};
          end
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_data_r  <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `LA_ASSERT_IMPL(a_live_count, clk, rst_n, 1'b1, $countones(live_all) == 32'(live_r))
  `LA_ASSERT_IMPL(a_total, clk, rst_n, 1'b1, total_r == lotarb_pkg::TOTAL_W'(live_r * TICKETS_EACH))
  `LA_ASSERT_IMPL(a_winner_live, clk, rst_n, winner_valid_r, live_all[winner_r])
  `LA_ASSERT_IMPL(a_one_token, clk, rst_n, 1'b1, $onehot0(actives))
  `LA_ASSERT_NEXT(a_token_done, clk, rst_n, (state_r == ST_SCAN) && tail.active, state_r == ST_FIN)

endmodule

`default_nettype wire

FILE: src/lotarb_cell.sv
`default_nettype none

module lotarb_cell (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [lotarb_pkg::TICKET_W-1:0] tickets,
  input  wire logic [lotarb_pkg::IDX_W-1:0]    slot_idx,
  input  wire lotarb_pkg::lotarb_link_t        link_in,
  input  wire logic                           retire,
  input  wire logic [lotarb_pkg::IDX_W-1:0]    retire_idx,
  output logic                                live,
  output lotarb_pkg::lotarb_link_t             link_out
);

  logic                              live_r;
  logic                              live_nxt;
  lotarb_pkg::lotarb_link_t          link_r;
  lotarb_pkg::lotarb_link_t          link_nxt;
  logic [lotarb_pkg::TOTAL_W:0]      upper;
  logic [lotarb_pkg::TARGET_W-1:0]   lo_bound;
  logic [lotarb_pkg::TARGET_W:0]     hi_bound;
  logic                              hit;

  always_comb begin
    upper    = {1'b0, link_in.prefix} + (lotarb_pkg::TOTAL_W + 1)'(tickets);
    lo_bound = {link_in.prefix, {lotarb_pkg::FRAC_W{1'b0}}};
    hi_bound = {upper, {lotarb_pkg::FRAC_W{1'b0}}};
    hit      = (lo_bound < link_in.target) && ({1'b0, link_in.target} < hi_bound);

    link_nxt = link_in;
    if (link_in.active && live_r && !link_in.found) begin
      if (hit) begin
        link_nxt.found = 1'b1;
        link_nxt.idx   = slot_idx;
      end
      link_nxt.prefix = upper[lotarb_pkg::TOTAL_W-1:0];
    end

    // drop out of the lottery when this slot's winner is retired
    live_nxt = live_r && !(retire && (retire_idx == slot_idx));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b1;
      link_r <= '0;
    end else begin
      live_r <= live_nxt;
      link_r <= link_nxt;
    end
  end

  assign live     = live_r;
  assign link_out = link_r;

endmodule

`default_nettype wire

FILE: tb/lottery_arbiter_checker.sv
`timescale 1ns / 1ps

module lottery_arbiter_checker #(
  parameter int SLOTS        = 8,
  parameter int TICKETS_EACH = 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  lotarb_pkg::lotarb_in_t  in_data,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  lotarb_pkg::lotarb_out_t out_data,
  output int                      error_count,
  output int                      pending_count
);

  logic                            live_mark [lotarb_pkg::MAX_SLOTS];
  logic [lotarb_pkg::TICKET_W-1:0] slot_tix [lotarb_pkg::MAX_SLOTS];
  logic [lotarb_pkg::TOTAL_W-1:0]  ticket_sum;
  logic [lotarb_pkg::LIVE_W-1:0]   live_num;
  logic [lotarb_pkg::IDX_W-1:0]    winner_idx;
  logic                            winner_held;

  lotarb_pkg::lotarb_out_t expected_results[$];
  int                      result_num;

  task automatic clear_state();
    for (int i = 0; i < lotarb_pkg::MAX_SLOTS; i++) begin
      live_mark[i] = (i < SLOTS);
      slot_tix[i]  = lotarb_pkg::TICKET_W'(TICKETS_EACH);
    end
    ticket_sum  = lotarb_pkg::TOTAL_W'(SLOTS * TICKETS_EACH);
    live_num    = lotarb_pkg::LIVE_W'(SLOTS);
    winner_idx  = '0;
    winner_held = 1'b0;
  endtask

  // Apply one item to the arbiter state and return the result it produces.
  function automatic lotarb_pkg::lotarb_out_t arbitrate(input lotarb_pkg::lotarb_in_t item);
    lotarb_pkg::lotarb_out_t res;
    int unsigned target;
    int unsigned prefix;
    int unsigned tix;
    logic        found;
    res        = '0;
    res.drew   = 1'b0;
    res.status = lotarb_pkg::STATUS_DONE;
    if (item.command == lotarb_pkg::CMD_DRAW) begin
      if (live_num == 0 || ticket_sum == 0) begin
        res.status = lotarb_pkg::STATUS_IGNORED;
      end else begin
        target = 32'(item.random_fraction) * 32'(ticket_sum);
        prefix = 0;
        found  = 1'b0;
        // strict bounds on both sides: a target on a range edge wins nothing
        for (int i = 0; i < SLOTS; i++) begin
          if (!found && live_mark[i]) begin
            tix = 32'(slot_tix[i]);
            if (prefix * 65536 < target && target < (prefix + tix) * 65536) begin
              winner_idx  = lotarb_pkg::IDX_W'(i);
              winner_held = 1'b1;
              res.drew    = 1'b1;
              found       = 1'b1;
            end else begin
              prefix = prefix + tix;
            end
          end
        end
      end
    end else begin
      if (!winner_held || !live_mark[winner_idx]) begin
        res.status = lotarb_pkg::STATUS_IGNORED;
      end else begin
        live_mark[winner_idx] = 1'b0;
        ticket_sum = (ticket_sum >= lotarb_pkg::TOTAL_W'(slot_tix[winner_idx])) ?
                     ticket_sum - lotarb_pkg::TOTAL_W'(slot_tix[winner_idx]) : '0;
        if (live_num > 0) begin
          live_num = live_num - 1'b1;
        end
        winner_held = 1'b0;
      end
    end
    res.winner       = winner_idx;
    res.live_count   = live_num;
    res.ticket_total = ticket_sum;
    return res;
  endfunction

  always @(posedge clk) begin : watch
    lotarb_pkg::lotarb_out_t want;
    if (!rst_n) begin
      clear_state();
      expected_results.delete();
      error_count = 0;
      result_num  = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(arbitrate(in_data));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          error_count++;
          if (error_count <= 10) begin
            $display("result %0d arrived with nothing expected: %p", result_num, out_data);
          end
        end else begin
          want = expected_results.pop_front();
          if (want.winner !== out_data.winner || want.drew !== out_data.drew ||
              want.status !== out_data.status || want.live_count !== out_data.live_count ||
              want.ticket_total !== out_data.ticket_total) begin
            error_count++;
            if (error_count <= 10) begin
              $display("result %0d wrong: winner %0d/%0d drew %0d/%0d status %0d/%0d",
                       result_num, want.winner, out_data.winner, want.drew, out_data.drew,
                       want.status, out_data.status);
              $display("  live %0d/%0d total %0d/%0d (expected/actual)",
                       want.live_count, out_data.live_count,
                       want.ticket_total, out_data.ticket_total);
            end
          end
        end
        result_num++;
      end
    end
    pending_count = expected_results.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int SLOTS        = 8;
  localparam int TICKETS_EACH = 5;
  localparam int PHASE_ITEMS  = 100;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic                    out_ready = 1'b0;
  lotarb_pkg::lotarb_in_t  in_data   = '0;
  logic                    in_ready;
  logic                    out_valid;
  lotarb_pkg::lotarb_out_t out_data;

  int idle_pct  = 0;
  int stall_pct = 0;
  int error_count;
  int pending_count;

  lottery_arbiter_top #(
    .SLOTS        (SLOTS),
    .TICKETS_EACH (TICKETS_EACH)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  lottery_arbiter_checker #(
    .SLOTS        (SLOTS),
    .TICKETS_EACH (TICKETS_EACH)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);
  end

  // Present one item and hold it until the arbiter takes it.
  task automatic send(input logic cmd, input logic [lotarb_pkg::FRAC_W-1:0] frac);
    lotarb_pkg::lotarb_in_t item;
    item.command         = cmd;
    item.random_fraction = frac;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic draw(input logic [lotarb_pkg::FRAC_W-1:0] frac);
    send(lotarb_pkg::CMD_DRAW, frac);
    idle_gap();
  endtask

  task automatic retire();
    send(lotarb_pkg::CMD_RETIRE, lotarb_pkg::FRAC_W'($urandom));
    idle_gap();
  endtask

  // Hold off the sender until every outstanding result is back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  task automatic random_item();
    int pick;
    int frac_kind;
    pick = $urandom_range(999);
    if (pick < 20) begin
      retire();
    end else if (pick < 26) begin
      // back-to-back retire: second one has no live winner
      retire();
      retire();
    end else begin
      frac_kind = $urandom_range(19);
      if (frac_kind == 0) begin
        draw('0);
      end else if (frac_kind == 1) begin
        draw('1);
      end else begin
        draw(lotarb_pkg::FRAC_W'($urandom));
      end
    end
  endtask

  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: edges of the ticket ranges, retire without winner, double retire
    retire();
    draw(16'h0000);
    draw(16'hFFFF);
    draw(16'd8192);
    draw(16'd8193);
    draw(16'h0001);
    retire();
    retire();
    draw(16'h8000);
    draw(16'hAAAA);
    draw(16'h5555);
    draw(16'h7FFF);
    retire();
    draw(16'h3000);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 70;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 70;
        end
        default: begin
          idle_pct  = 28;
          stall_pct = 28;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        random_item();
      end
      drain();
    end

    // retire whatever is left, then draw with nothing live
    idle_pct  = 0;
    stall_pct = 0;
    for (int n = 0; n < 40; n++) begin
      draw(lotarb_pkg::FRAC_W'($urandom));
      retire();
    end
    draw('1);
    draw(lotarb_pkg::FRAC_W'($urandom));
    retire();
    drain();

    repeat (SLOTS + 8) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: lottery_arbiter_top.f
+incdir+src
src/lotarb_pkg.sv
src/lotarb_cell.sv
src/lottery_arbiter_top.sv
tb/lottery_arbiter_checker.sv
tb/testbench.sv
